/* rtl/lsoc_pkg.sv */
// ----------------------------------------------------------------------------
// LQR steering observer control package
// Shared constants, datapath command types, controller states and the
// microcode program that sequences one control tick.
// ----------------------------------------------------------------------------
`default_nettype none

package lsoc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int C045      = (45 * ONE + 50) / 100;
  localparam int C03       = (3 * ONE + 5) / 10;

  // Accumulator width: a few saturated 32-bit terms plus headroom.
  localparam int ACC_W     = 40;
  // Dividend of a quotient is the 32-bit value shifted up by the fraction.
  localparam int DIV_W     = 32 + FRAC_BITS;
  // Floor division by 60 as a multiply by ceil(2^37 / 60) and a shift.
  localparam int DIV60_SH  = 37;
  localparam longint RECIP60 = 64'd2290649225;

  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_SCALE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_STEPS  = 3'd7;

  typedef enum logic [5:0] {
    OP_ZERO, OP_SPEED, OP_RECIP, OP_C045, OP_Q60, OP_FM, OP_DIVQ, OP_UNWS,
    OP_MEAS, OP_TORQUE, OP_TARGET, OP_BIAS,
    OP_BASE, OP_TS, OP_AK, OP_DES, OP_ANG, OP_E, OP_TQ, OP_DQ, OP_X0, OP_X1,
    OP_U, OP_FBP, OP_FB, OP_ERR, OP_CAND, OP_INTEG, OP_OBS0, OP_OBS1,
    OP_A00, OP_A01, OP_A10, OP_A11, OP_B0, OP_B1, OP_C0, OP_C1,
    OP_K0, OP_K1, OP_L0, OP_L1, OP_DC, OP_SC, OP_KI
  } opnd_e;

  typedef enum logic [4:0] {
    D_NONE, D_BASE, D_TS, D_AK, D_DES, D_ANG, D_E, D_TQ, D_DQ, D_X0, D_X1,
    D_U, D_FBP, D_FB, D_ERR, D_CAND, D_CTRL, D_UNW, D_CMD, D_EST
  } dst_e;

  typedef enum logic [1:0] {A_NOP, A_LOAD, A_ADD, A_SUB} aop_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_e;

  typedef struct packed {
    logic  mul_en;
    opnd_e mul_a;
    opnd_e mul_b;
    logic  rnd_en;
    aop_e  aop;
    opnd_e asrc;
    dst_e  dst;
    logic  div_go;
    opnd_e div_a;
    opnd_e div_b;
    logic  commit;
    logic  last;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic capture;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(signed'(32'h7fff_ffff))) begin
      r = signed'(32'h7fff_ffff);
    end else if (v < ACC_W'(signed'(32'h8000_0000))) begin
      r = signed'(32'h8000_0000);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // One tick of work. A product issued at step k is rounded at k+1 and may
  // be accumulated at k+2; accumulator writes land one step after the sum.
  function automatic cmd_t ucode(logic [PC_W-1:0] pc);
    cmd_t c;
    c = '0;
    case (pc)
      6'd0: begin c.mul_en = 1'b1; c.mul_a = OP_SPEED; c.mul_b = OP_RECIP; end
      6'd1: begin c.aop = A_LOAD; c.asrc = OP_Q60; end
      6'd2: begin c.aop = A_ADD; c.asrc = OP_C045; end
      6'd3: begin c.dst = D_BASE; end
      6'd4: begin c.mul_en = 1'b1; c.mul_a = OP_BASE; c.mul_b = OP_BASE; end
      6'd5: begin c.rnd_en = 1'b1; end
      6'd6: begin c.aop = A_LOAD; c.asrc = OP_FM; end
      6'd7: begin
        c.dst = D_TS; c.mul_en = 1'b1; c.mul_a = OP_C0; c.mul_b = OP_OBS0;
      end
      6'd8: begin
        c.rnd_en = 1'b1; c.mul_en = 1'b1; c.mul_a = OP_C1; c.mul_b = OP_OBS1;
      end
      6'd9: begin c.aop = A_LOAD; c.asrc = OP_FM; c.rnd_en = 1'b1; end
      6'd10: begin c.aop = A_ADD; c.asrc = OP_FM; end
      6'd11: begin c.dst = D_AK; c.aop = A_LOAD; c.asrc = OP_TARGET; end
      6'd12: begin c.aop = A_SUB; c.asrc = OP_BIAS; end
      6'd13: begin c.dst = D_DES; c.aop = A_LOAD; c.asrc = OP_MEAS; end
      6'd14: begin c.aop = A_SUB; c.asrc = OP_BIAS; end
      6'd15: begin c.dst = D_ANG; end
      6'd16: begin c.aop = A_LOAD; c.asrc = OP_ANG; end
      6'd17: begin c.aop = A_SUB; c.asrc = OP_AK; end
      6'd18: begin
        c.dst = D_E; c.div_go = 1'b1; c.div_a = OP_TORQUE; c.div_b = OP_TS;
      end
      6'd19: begin c.aop = A_LOAD; c.asrc = OP_DIVQ; end
      6'd20: begin
        c.dst = D_TQ; c.div_go = 1'b1; c.div_a = OP_DES; c.div_b = OP_DC;
      end
      6'd21: begin c.aop = A_LOAD; c.asrc = OP_DIVQ; end
      6'd22: begin
        c.dst = D_DQ; c.mul_en = 1'b1; c.mul_a = OP_A00; c.mul_b = OP_OBS0;
      end
      6'd23: begin
        c.rnd_en = 1'b1; c.mul_en = 1'b1; c.mul_a = OP_A01; c.mul_b = OP_OBS1;
      end
      6'd24: begin
        c.aop = A_LOAD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_B0; c.mul_b = OP_TQ;
      end
      6'd25: begin
        c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_L0; c.mul_b = OP_E;
      end
      6'd26: begin
        c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_A10; c.mul_b = OP_OBS0;
      end
      6'd27: begin
        c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_A11; c.mul_b = OP_OBS1;
      end
      6'd28: begin
        c.dst = D_X0; c.aop = A_LOAD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_B1; c.mul_b = OP_TQ;
      end
      6'd29: begin
        c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_L1; c.mul_b = OP_E;
      end
      6'd30: begin
        c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1;
        c.mul_en = 1'b1; c.mul_a = OP_K0; c.mul_b = OP_X0;
      end
      6'd31: begin c.aop = A_ADD; c.asrc = OP_FM; c.rnd_en = 1'b1; end
      6'd32: begin c.dst = D_X1; c.aop = A_LOAD; c.asrc = OP_DQ; end
      6'd33: begin
        c.aop = A_SUB; c.asrc = OP_FM;
        c.mul_en = 1'b1; c.mul_a = OP_K1; c.mul_b = OP_X1;
      end
      6'd34: begin c.rnd_en = 1'b1; end
      6'd35: begin c.aop = A_SUB; c.asrc = OP_FM; end
      6'd36: begin c.dst = D_U; end
      6'd37: begin c.mul_en = 1'b1; c.mul_a = OP_TS; c.mul_b = OP_U; end
      6'd38: begin c.rnd_en = 1'b1; end
      6'd39: begin c.aop = A_LOAD; c.asrc = OP_FM; end
      6'd40: begin c.dst = D_FBP; end
      6'd41: begin c.div_go = 1'b1; c.div_a = OP_FBP; c.div_b = OP_SC; end
      6'd42: begin c.aop = A_LOAD; c.asrc = OP_DIVQ; end
      6'd43: begin c.dst = D_FB; c.aop = A_LOAD; c.asrc = OP_DES; end
      6'd44: begin c.aop = A_SUB; c.asrc = OP_AK; end
      6'd45: begin c.dst = D_ERR; end
      6'd46: begin c.mul_en = 1'b1; c.mul_a = OP_KI; c.mul_b = OP_ERR; end
      6'd47: begin c.rnd_en = 1'b1; end
      6'd48: begin c.aop = A_LOAD; c.asrc = OP_INTEG; end
      6'd49: begin c.aop = A_ADD; c.asrc = OP_FM; end
      6'd50: begin c.dst = D_CAND; c.aop = A_LOAD; c.asrc = OP_FB; end
      6'd51: begin c.aop = A_ADD; c.asrc = OP_CAND; end
      6'd52: begin c.dst = D_CTRL; c.aop = A_LOAD; c.asrc = OP_INTEG; end
      6'd53: begin c.aop = A_ADD; c.asrc = OP_UNWS; end
      6'd54: begin c.dst = D_UNW; end
      6'd55: begin c.commit = 1'b1; end
      6'd56: begin c.aop = A_LOAD; c.asrc = OP_FB; end
      6'd57: begin c.aop = A_ADD; c.asrc = OP_INTEG; end
      6'd58: begin c.dst = D_CMD; c.aop = A_LOAD; c.asrc = OP_AK; end
      6'd59: begin c.aop = A_ADD; c.asrc = OP_BIAS; end
      6'd60: begin c.dst = D_EST; c.last = 1'b1; end
      default: begin c.last = 1'b1; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/lsoc_div.sv */
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring division of (a << FRAC_BITS) by b, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lsoc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [31:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import lsoc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [32:0]      rem_q, rem_d;
  logic [31:0]      den_q, den_d;
  logic             neg_q, neg_d;
  logic             zero_q, zero_d;
  logic             apos_q, apos_d;

  logic [31:0]      mag_a, mag_b;
  logic [32:0]      rem_sh;
  logic             fits;

  assign mag_a  = dividend_i[31] ? 32'(-dividend_i) : 32'(dividend_i);
  assign mag_b  = divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
  assign rem_sh = {rem_q[31:0], num_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    apos_d = apos_q;
    if (go_i) begin
      neg_d  = dividend_i[31] ^ divisor_i[31];
      apos_d = (dividend_i > 0);
      num_d  = {mag_a, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      den_d  = mag_b;
      cnt_d  = CNT_W'(DIV_W);
      if (divisor_i == '0) begin
        // A zero divisor answers at once with the saturated sign of a.
        zero_d = 1'b1;
        neg_d  = dividend_i[31];
        done_d = 1'b1;
      end else begin
        zero_d = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_d = {num_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    apos_q <= apos_d;
  end

  always_comb begin
    if (zero_q) begin
      if (apos_q) quot_o = signed'(32'h7fff_ffff);
      else if (neg_q) quot_o = signed'(32'h8000_0000);
      else quot_o = '0;
    end else if (neg_q) begin
      if (num_q > DIV_W'(33'h0_8000_0000)) quot_o = signed'(32'h8000_0000);
      else quot_o = signed'(32'(-num_q));
    end else begin
      if (num_q > DIV_W'(32'h7fff_ffff)) quot_o = signed'(32'h7fff_ffff);
      else quot_o = signed'(num_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

/* rtl/lsoc_dp.sv */
// ----------------------------------------------------------------------------
// LQR steering observer datapath
// Configuration registers, one rounding multiplier, a saturating
// accumulator, the work registers of one tick, observer and integrator
// state, the divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsoc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lsoc_pkg::ctl_t                   ctl_i,
  output lsoc_pkg::sts_t                   sts_o,
  input  logic                             cfg_we_i,
  input  logic [lsoc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [63:0]                      cfg_data_i,
  input  logic                             enable_i,
  input  logic [30:0]                      speed_i,
  input  logic signed [31:0]               measured_angle_i,
  input  logic signed [31:0]               motor_torque_i,
  input  logic                             driver_override_i,
  input  logic signed [31:0]               target_angle_i,
  input  logic signed [31:0]               angle_bias_i,
  input  logic [30:0]                      steer_limit_i,
  output logic signed [31:0]               steer_command_o,
  output logic signed [31:0]               offset_target_angle_o,
  output logic signed [31:0]               estimated_angle_o,
  output logic signed [31:0]               integrator_value_o,
  output logic signed [31:0]               feedback_term_o,
  output logic                             loop_active_o
);
  import lsoc_pkg::*;

  logic [63:0] cfg_q [CFG_NUM];

  // Item captured on acceptance.
  logic               en_q, ovr_q;
  logic [30:0]        spd_q, lim_q;
  logic signed [31:0] meas_q, trq_q, tgt_q, bias_q;

  // Work registers of one tick.
  logic signed [31:0] base_q, ts_q, ak_q, des_q, ang_q, e_q, tq_q, dq_q;
  logic signed [31:0] x0_q, x1_q, u_q, fbp_q, fb_q, err_q, cand_q, ctrl_q;
  logic signed [31:0] unw_q, cmd_q, est_q;

  logic signed [31:0] obs0_q, obs1_q, integ_q, integ_d;

  logic signed [65:0]      prod_q;
  logic signed [65:0]      rnd;
  logic signed [31:0]      fm_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] asrc_v, mula_v, mulb_v, diva_v, divb_v;
  logic signed [31:0]      wval, clip_v;
  logic signed [32:0]      lim33, cv33, ctrl33;
  logic                    active, hold_ok;
  logic                    div_done;
  logic signed [31:0]      div_q;

  assign active = en_q && (spd_q >= 31'(C03));

  function automatic logic signed [ACC_W-1:0] ext(logic signed [31:0] v);
    return ACC_W'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] opnd(opnd_e s);
    logic signed [ACC_W-1:0] v;
    case (s)
      OP_SPEED:  v = signed'(ACC_W'(spd_q));
      OP_RECIP:  v = signed'(ACC_W'(RECIP60));
      OP_C045:   v = signed'(ACC_W'(C045));
      OP_Q60:    v = signed'(ACC_W'(prod_q >>> DIV60_SH));
      OP_FM:     v = ext(fm_q);
      OP_DIVQ:   v = ext(div_q);
      OP_UNWS: begin
        // Step toward zero; a zero integrator stays put.
        if (integ_q > 0) v = -ext(signed'(cfg_q[CFG_INT_STEPS][31:0]));
        else if (integ_q < 0) v = ext(signed'(cfg_q[CFG_INT_STEPS][31:0]));
        else v = '0;
      end
      OP_MEAS:   v = ext(meas_q);
      OP_TORQUE: v = ext(trq_q);
      OP_TARGET: v = ext(tgt_q);
      OP_BIAS:   v = ext(bias_q);
      OP_BASE:   v = ext(base_q);
      OP_TS:     v = ext(ts_q);
      OP_AK:     v = ext(ak_q);
      OP_DES:    v = ext(des_q);
      OP_ANG:    v = ext(ang_q);
      OP_E:      v = ext(e_q);
      OP_TQ:     v = ext(tq_q);
      OP_DQ:     v = ext(dq_q);
      OP_X0:     v = ext(x0_q);
      OP_X1:     v = ext(x1_q);
      OP_U:      v = ext(u_q);
      OP_FBP:    v = ext(fbp_q);
      OP_FB:     v = ext(fb_q);
      OP_ERR:    v = ext(err_q);
      OP_CAND:   v = ext(cand_q);
      OP_INTEG:  v = ext(integ_q);
      OP_OBS0:   v = ext(obs0_q);
      OP_OBS1:   v = ext(obs1_q);
      OP_A00:    v = ext(signed'(cfg_q[CFG_MODEL_ROW0][63:32]));
      OP_A01:    v = ext(signed'(cfg_q[CFG_MODEL_ROW0][31:0]));
      OP_A10:    v = ext(signed'(cfg_q[CFG_MODEL_ROW1][63:32]));
      OP_A11:    v = ext(signed'(cfg_q[CFG_MODEL_ROW1][31:0]));
      OP_B0:     v = ext(signed'(cfg_q[CFG_INPUT_GAIN][63:32]));
      OP_B1:     v = ext(signed'(cfg_q[CFG_INPUT_GAIN][31:0]));
      OP_C0:     v = ext(signed'(cfg_q[CFG_OUTPUT_GAIN][63:32]));
      OP_C1:     v = ext(signed'(cfg_q[CFG_OUTPUT_GAIN][31:0]));
      OP_K0:     v = ext(signed'(cfg_q[CFG_FB_GAIN][63:32]));
      OP_K1:     v = ext(signed'(cfg_q[CFG_FB_GAIN][31:0]));
      OP_L0:     v = ext(signed'(cfg_q[CFG_OBS_GAIN][63:32]));
      OP_L1:     v = ext(signed'(cfg_q[CFG_OBS_GAIN][31:0]));
      OP_DC:     v = ext(signed'(cfg_q[CFG_DC_SCALE][63:32]));
      OP_SC:     v = ext(signed'(cfg_q[CFG_DC_SCALE][31:0]));
      OP_KI:     v = ext(signed'(cfg_q[CFG_INT_STEPS][63:32]));
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    asrc_v = opnd(ctl_i.cmd.asrc);
    mula_v = opnd(ctl_i.cmd.mul_a);
    mulb_v = opnd(ctl_i.cmd.mul_b);
    diva_v = opnd(ctl_i.cmd.div_a);
    divb_v = opnd(ctl_i.cmd.div_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_q[i] <= (i == int'(CFG_DC_SCALE)) ? {32'(ONE), 32'(ONE)} : '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      en_q   <= enable_i;
      spd_q  <= speed_i;
      meas_q <= measured_angle_i;
      trq_q  <= motor_torque_i;
      ovr_q  <= driver_override_i;
      tgt_q  <= target_angle_i;
      bias_q <= angle_bias_i;
      lim_q  <= steer_limit_i;
    end
  end

  // Round half up at the fraction point, then saturate.
  assign rnd = (prod_q + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd.mul_en) prod_q <= $signed(mula_v[32:0]) * $signed(mulb_v[32:0]);
    if (ctl_i.cmd.rnd_en) begin
      if (rnd > 66'sh0_7fff_ffff) fm_q <= signed'(32'h7fff_ffff);
      else if (rnd < -66'sh0_8000_0000) fm_q <= signed'(32'h8000_0000);
      else fm_q <= rnd[31:0];
    end
    case (ctl_i.cmd.aop)
      A_LOAD:  acc_q <= asrc_v;
      A_ADD:   acc_q <= acc_q + asrc_v;
      A_SUB:   acc_q <= acc_q - asrc_v;
      default: acc_q <= acc_q;
    endcase
  end

  assign wval   = sat32(acc_q);
  assign lim33  = signed'({2'b00, lim_q});
  assign cv33   = 33'(wval);
  assign ctrl33 = 33'(ctrl_q);

  always_comb begin
    if (!active) clip_v = '0;
    else if (cv33 > lim33) clip_v = lim33[31:0];
    else if (cv33 < -lim33) clip_v = 32'(-lim33);
    else clip_v = wval;
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd.dst)
      D_BASE:  base_q <= wval;
      D_TS:    ts_q   <= wval;
      D_AK:    ak_q   <= wval;
      D_DES:   des_q  <= wval;
      D_ANG:   ang_q  <= wval;
      D_E:     e_q    <= wval;
      D_TQ:    tq_q   <= wval;
      D_DQ:    dq_q   <= wval;
      D_X0:    x0_q   <= wval;
      D_X1:    x1_q   <= wval;
      D_U:     u_q    <= wval;
      D_FBP:   fbp_q  <= wval;
      D_FB:    fb_q   <= wval;
      D_ERR:   err_q  <= wval;
      D_CAND:  cand_q <= wval;
      D_CTRL:  ctrl_q <= wval;
      D_UNW:   unw_q  <= wval;
      D_CMD:   cmd_q  <= clip_v;
      D_EST:   est_q  <= wval;
      default: ;
    endcase
  end

  // Anti-windup: keep the new sum only if it does not push a saturated
  // command further past the limit.
  assign hold_ok = ((err_q >= 0) && ((ctrl33 <= lim33) || (cand_q < 0))) ||
                   ((err_q <= 0) && ((ctrl33 >= -lim33) || (cand_q > 0)));

  always_comb begin
    if (!active) integ_d = '0;
    else if (ovr_q) integ_d = unw_q;
    else if (hold_ok) integ_d = cand_q;
    else integ_d = integ_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs0_q  <= '0;
      obs1_q  <= '0;
      integ_q <= '0;
    end else if (ctl_i.cmd.commit) begin
      obs0_q  <= x0_q;
      obs1_q  <= x1_q;
      integ_q <= integ_d;
    end
  end

  lsoc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (ctl_i.cmd.div_go),
    .dividend_i (diva_v[31:0]),
    .divisor_i  (divb_v[31:0]),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      steer_command_o       <= cmd_q;
      offset_target_angle_o <= des_q;
      estimated_angle_o     <= est_q;
      integrator_value_o    <= integ_q;
      feedback_term_o       <= active ? fb_q : '0;
      loop_active_o         <= active;
    end
  end

endmodule

`default_nettype wire

/* rtl/lsoc_ctrl.sv */
// ----------------------------------------------------------------------------
// LQR steering observer controller
// Steps the microcode program, waits on the divider and hands each result
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsoc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  lsoc_pkg::sts_t sts_i,
  output lsoc_pkg::ctl_t ctl_o
);
  import lsoc_pkg::*;

  state_e          state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  cmd_t            cur;

  assign cur = ucode(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        pc_d = '0;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cur.div_go) begin
          state_d = ST_WAIT;
        end else if (cur.last) begin
          state_d = ST_DONE;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_RUN;
          pc_d    = pc_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    if (state_q == ST_RUN) ctl_o.cmd = cur;
    in_stall_o     = (state_q != ST_IDLE);
  end

  // The output beat is held until taken; a new one replaces it only then.
  assign out_valid_d = ctl_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/lqr_steering_observer_control.sv */
// ----------------------------------------------------------------------------
// LQR steering observer control
// Two-state observer, LQR feedback and anti-windup integrator per tick.
// ----------------------------------------------------------------------------
// Each input beat runs through 61 microcode steps, three of which wait on the serial
// divider (a zero divisor answers at once), and is then handed to the output register.
// A new item is taken only once the last one has been handed on; a finished
// result waits in the output register while the next item is taken.
// Reset clears the observer, the integrator and all configuration registers
// (DC gain and output scale to one); no clearing pass is needed.
`default_nettype none

module lqr_steering_observer_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           enable_i,
  input  logic [30:0]                    speed_i,
  input  logic signed [31:0]             measured_angle_i,
  input  logic signed [31:0]             motor_torque_i,
  input  logic                           driver_override_i,
  input  logic signed [31:0]             target_angle_i,
  input  logic signed [31:0]             angle_bias_i,
  input  logic [30:0]                    steer_limit_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             steer_command_o,
  output logic signed [31:0]             offset_target_angle_o,
  output logic signed [31:0]             estimated_angle_o,
  output logic signed [31:0]             integrator_value_o,
  output logic signed [31:0]             feedback_term_o,
  output logic                           loop_active_o,
  input  logic                           cfg_we_i,
  input  logic [lsoc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                    cfg_data_i
);
  import lsoc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lsoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  lsoc_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .ctl_i                 (ctl),
    .sts_o                 (sts),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .enable_i              (enable_i),
    .speed_i               (speed_i),
    .measured_angle_i      (measured_angle_i),
    .motor_torque_i        (motor_torque_i),
    .driver_override_i     (driver_override_i),
    .target_angle_i        (target_angle_i),
    .angle_bias_i          (angle_bias_i),
    .steer_limit_i         (steer_limit_i),
    .steer_command_o       (steer_command_o),
    .offset_target_angle_o (offset_target_angle_o),
    .estimated_angle_o     (estimated_angle_o),
    .integrator_value_o    (integrator_value_o),
    .feedback_term_o       (feedback_term_o),
    .loop_active_o         (loop_active_o)
  );

  // An inactive tick reports zero command, feedback and integrator.
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !loop_active_o |->
      (steer_command_o == '0) && (feedback_term_o == '0) &&
      (integrator_value_o == '0))
    else $error("inactive result carries nonzero control values");

  // Once an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted again before the tick finished");

  // A new result only appears at the end of a tick in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> in_stall_o && !ctl.capture)
    else $error("output loaded without a tick in progress");

  // The divider never finishes while the program is stepping ahead.
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |-> !ctl.cmd.div_go && (ctl.cmd.aop == A_NOP))
    else $error("divider finished outside a wait");

endmodule

`default_nettype wire

/* tb/lsoc_checker.sv */
// ----------------------------------------------------------------------------
// LQR steering observer control: result checker
// Watches the configuration port and both channels, keeps its own copy of the
// observer, integrator and coefficients, predicts each result beat and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
`default_nettype none

module lsoc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           enable_i,
  input  logic [30:0]                    speed_i,
  input  logic signed [31:0]             measured_angle_i,
  input  logic signed [31:0]             motor_torque_i,
  input  logic                           driver_override_i,
  input  logic signed [31:0]             target_angle_i,
  input  logic signed [31:0]             angle_bias_i,
  input  logic [30:0]                    steer_limit_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic signed [31:0]             steer_command_i,
  input  logic signed [31:0]             offset_target_angle_i,
  input  logic signed [31:0]             estimated_angle_i,
  input  logic signed [31:0]             integrator_value_i,
  input  logic signed [31:0]             feedback_term_i,
  input  logic                           loop_active_i,
  input  logic                           cfg_we_i,
  input  logic [lsoc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                    cfg_data_i,
  output int                             pending_o,
  output int                             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsoc_pkg::*;

  localparam int     FB    = 16;
  localparam longint QONE  = longint'(1) << FB;
  localparam longint K045  = (45 * QONE + 50) / 100;
  localparam longint K03   = (3 * QONE + 5) / 10;
  localparam longint QMAX  = 64'sd2147483647;
  localparam longint QMIN  = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] command;
    logic signed [31:0] desired;
    logic signed [31:0] estimate;
    logic signed [31:0] integ;
    logic signed [31:0] feedback;
    logic               active;
  } tick_result_t;

  logic [63:0]  coeff_regs [CFG_NUM];
  longint       obs_a, obs_b, integ_acc;
  tick_result_t awaited_ticks [$];

  function automatic longint clamp32(longint x);
    if (x > QMAX) return QMAX;
    if (x < QMIN) return QMIN;
    return x;
  endfunction

  // Product rounded half up: add half an LSB, then an arithmetic (floor) shift.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (longint'(1) << (FB - 1));
    return clamp32(p >>> FB);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return (a > 0) ? QMAX : (a < 0) ? QMIN : 0;
    return clamp32((a <<< FB) / b);
  endfunction

  function automatic longint upper(logic [63:0] r);
    return longint'($signed(r[63:32]));
  endfunction

  function automatic longint lower(logic [63:0] r);
    return longint'($signed(r[31:0]));
  endfunction

  function automatic tick_result_t control_tick();
    tick_result_t r;
    longint spd, lim, bias, base, ts, des, ang, ak, e, tq, x0, x1, u, err, cand, ctrl;
    longint cmd, fbk;
    logic act;
    spd  = longint'(speed_i);
    lim  = longint'(steer_limit_i);
    bias = longint'(angle_bias_i);
    cmd  = 0;
    fbk  = 0;
    base = clamp32(K045 + spd / 60);
    ts   = qmul(base, base);
    des  = clamp32(longint'(target_angle_i) - bias);
    ang  = clamp32(longint'(measured_angle_i) - bias);
    ak   = clamp32(qmul(upper(coeff_regs[CFG_OUTPUT_GAIN]), obs_a) +
                   qmul(lower(coeff_regs[CFG_OUTPUT_GAIN]), obs_b));
    e    = clamp32(ang - ak);
    tq   = qdiv(longint'(motor_torque_i), ts);
    x0   = clamp32(qmul(upper(coeff_regs[CFG_MODEL_ROW0]), obs_a) +
                   qmul(lower(coeff_regs[CFG_MODEL_ROW0]), obs_b) +
                   qmul(upper(coeff_regs[CFG_INPUT_GAIN]), tq) +
                   qmul(upper(coeff_regs[CFG_OBS_GAIN]), e));
    x1   = clamp32(qmul(upper(coeff_regs[CFG_MODEL_ROW1]), obs_a) +
                   qmul(lower(coeff_regs[CFG_MODEL_ROW1]), obs_b) +
                   qmul(lower(coeff_regs[CFG_INPUT_GAIN]), tq) +
                   qmul(lower(coeff_regs[CFG_OBS_GAIN]), e));
    obs_a = x0;
    obs_b = x1;
    act = enable_i && (spd >= K03);
    if (!act) begin
      integ_acc = 0;
    end else begin
      u = clamp32(qdiv(des, upper(coeff_regs[CFG_DC_SCALE])) -
                  (qmul(upper(coeff_regs[CFG_FB_GAIN]), x0) +
                   qmul(lower(coeff_regs[CFG_FB_GAIN]), x1)));
      fbk = qdiv(qmul(ts, u), lower(coeff_regs[CFG_DC_SCALE]));
      if (driver_override_i) begin
        // Unwind walks toward zero and may overshoot it; zero stays put.
        if (integ_acc > 0) begin
          integ_acc = clamp32(integ_acc - lower(coeff_regs[CFG_INT_STEPS]));
        end else if (integ_acc < 0) begin
          integ_acc = clamp32(integ_acc + lower(coeff_regs[CFG_INT_STEPS]));
        end
      end else begin
        err  = clamp32(des - ak);
        cand = clamp32(integ_acc + qmul(upper(coeff_regs[CFG_INT_STEPS]), err));
        ctrl = clamp32(fbk + cand);
        if ((err >= 0 && (ctrl <= lim || cand < 0)) ||
            (err <= 0 && (ctrl >= -lim || cand > 0))) begin
          integ_acc = cand;
        end
      end
      cmd = clamp32(fbk + integ_acc);
      if (cmd > lim) cmd = lim;
      if (cmd < -lim) cmd = -lim;
    end
    r.command  = cmd[31:0];
    r.desired  = des[31:0];
    r.estimate = 32'(clamp32(ak + bias));
    r.integ    = integ_acc[31:0];
    r.feedback = fbk[31:0];
    r.active   = act;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        coeff_regs[i] <= (i == int'(CFG_DC_SCALE)) ? {32'h0001_0000, 32'h0001_0000} : '0;
      end
      obs_a     = 0;
      obs_b     = 0;
      integ_acc = 0;
      awaited_ticks.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (cfg_we_i) coeff_regs[cfg_idx_i] <= cfg_data_i;
      if (in_valid_i && !in_stall_i) awaited_ticks.push_back(control_tick());
      if (out_valid_i && !out_stall_i) begin
        if (awaited_ticks.size() == 0) begin
          $error("result beat with no tick outstanding");
          errors_o++;
        end else begin
          want = awaited_ticks.pop_front();
          check_field("steer_command", want.command, steer_command_i);
          check_field("offset_target_angle", want.desired, offset_target_angle_i);
          check_field("estimated_angle", want.estimate, estimated_angle_i);
          check_field("integrator_value", want.integ, integrator_value_i);
          check_field("feedback_term", want.feedback, feedback_term_i);
          check_field("loop_active", want.active, loop_active_i);
        end
      end
      pending_o = awaited_ticks.size();
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// LQR steering observer control: testbench top
// Drives directed and random control ticks through several coefficient
// settings with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsoc_pkg::*;

  localparam int HANG_LIMIT = 4000;
  localparam int QUIET_TAIL = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               enable = 1'b0;
  logic [30:0]        speed = '0;
  logic signed [31:0] meas_angle = '0;
  logic signed [31:0] torque = '0;
  logic               override = 1'b0;
  logic signed [31:0] target = '0;
  logic signed [31:0] bias = '0;
  logic [30:0]        limit = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] steer_command, offset_target, est_angle, integ_value, fb_term;
  logic               loop_active;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [63:0]        cfg_data = '0;
  int                 pending, errors;
  bit                 no_gaps = 1'b0;
  bit                 hold_request = 1'b0;
  int                 idle_cycles = 0;

  always #6 clk = ~clk;

  lqr_steering_observer_control u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .enable_i(enable), .speed_i(speed), .measured_angle_i(meas_angle),
    .motor_torque_i(torque), .driver_override_i(override),
    .target_angle_i(target), .angle_bias_i(bias), .steer_limit_i(limit),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .steer_command_o(steer_command), .offset_target_angle_o(offset_target),
    .estimated_angle_o(est_angle), .integrator_value_o(integ_value),
    .feedback_term_o(fb_term), .loop_active_o(loop_active),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  lsoc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .enable_i(enable), .speed_i(speed), .measured_angle_i(meas_angle),
    .motor_torque_i(torque), .driver_override_i(override),
    .target_angle_i(target), .angle_bias_i(bias), .steer_limit_i(limit),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .steer_command_i(steer_command), .offset_target_angle_i(offset_target),
    .estimated_angle_i(est_angle), .integrator_value_i(integ_value),
    .feedback_term_i(fb_term), .loop_active_i(loop_active),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  // Result side: random stalls, one long hold-off when asked for.
  initial begin
    int n;
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 11);
      if (hold_request) begin
        n = 700;
        hold_request = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(bit en, logic [30:0] spd, logic signed [31:0] ang,
                           logic signed [31:0] trq, bit ovr, logic signed [31:0] tgt,
                           logic signed [31:0] bs, logic [30:0] lim);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    enable     <= en;
    speed      <= spd;
    meas_angle <= ang;
    torque     <= trq;
    override   <= ovr;
    target     <= tgt;
    bias       <= bs;
    limit      <= lim;
    do @(posedge clk); while (in_stall);
  endtask

  // Lowers valid and waits for every outstanding tick to come back. The
  // extra edge lets the checker book the beat accepted at the last edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic load_coeffs(logic [63:0] vals [CFG_NUM]);
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coeff();
    int sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom();
      default: return 32'($signed($urandom_range(0, 196608)) - 98304);
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    if ($urandom_range(0, 15) == 0) return 32'h0;
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 131072)) - 65536 + ($urandom_range(0, 1) ? 98304 : -98304));
  endfunction

  function automatic logic signed [31:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
  endfunction

  function automatic logic [30:0] rand_speed();
    case ($urandom_range(0, 9))
      0: return 31'($urandom());
      1: return 31'($urandom_range(19600, 19720));
      2: return 31'($urandom_range(0, 19660));
      default: return 31'($urandom_range(0, 40 * 65536));
    endcase
  endfunction

  function automatic logic [30:0] rand_limit();
    case ($urandom_range(0, 9))
      0: return 31'($urandom());
      1: return '0;
      default: return 31'($urandom_range(0, 4 * 65536));
    endcase
  endfunction

  task automatic random_tick();
    send_tick($urandom_range(0, 7) != 0, rand_speed(), rand_angle(), rand_angle(),
              $urandom_range(0, 4) == 0, rand_angle(),
              32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536) ^
                ($urandom_range(0, 15) == 0 ? 32'h8000_0000 : 32'h0),
              rand_limit());
  endtask

  initial begin
    logic [63:0] coeffs [CFG_NUM];
    int burst_left;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: observer idle, scale and DC gain at one.
    send_tick(1'b0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_tick(1'b1, 31'd19660, 32'sd65536, 32'sd1000, 1'b0, 32'sd131072, 32'sd0, 31'd65536);
    send_tick(1'b1, 31'd19661, 32'sd65536, 32'sd1000, 1'b0, 32'sd131072, 32'sd0, 31'd65536);
    send_tick(1'b1, 31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'h7fff_ffff,
              32'h8000_0000, 31'h7fff_ffff);
    send_tick(1'b1, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000,
              32'h7fff_ffff, 31'h0);
    send_tick(1'b0, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff,
              32'h7fff_ffff, 31'h7fff_ffff);
    drain();

    // Integrator and feedback live, zero divisors on DC gain and scale.
    coeffs = '{64'h0000_8000_0000_4000, 64'hffff_c000_0000_e000,
               64'h0000_1000_ffff_f000, 64'h0001_0000_0000_0000,
               64'h0000_8000_0000_2000, 64'h0000_4000_0000_2000,
               64'h0000_0000_0000_0000, 64'h0000_2000_0000_1000};
    load_coeffs(coeffs);
    send_tick(1'b1, 31'd655360, 32'sd65536, 32'sd500, 1'b0, 32'sd327680, 32'sd0, 31'd65536);
    send_tick(1'b1, 31'd655360, -32'sd65536, -32'sd500, 1'b0, -32'sd327680, 32'sd0, 31'd65536);
    send_tick(1'b1, 31'd655360, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 31'd65536);
    coeffs[CFG_DC_SCALE] = 64'h0001_0000_0000_8000;
    drain();
    load_coeffs(coeffs);
    // Build up the integrator against a generous limit, then unwind it.
    repeat (4) send_tick(1'b1, 31'd655360, 32'sd0, 32'sd0, 1'b0, 32'sd655360, 32'sd0,
                         31'h7fff_ffff);
    repeat (3) send_tick(1'b1, 31'd655360, 32'sd0, 32'sd0, 1'b1, 32'sd655360, 32'sd0,
                         31'h7fff_ffff);
    // Tight limit holds the integrator; then inactive clears it.
    repeat (2) send_tick(1'b1, 31'd655360, 32'sd0, 32'sd0, 1'b0, 32'sd655360, 32'sd0, 31'd10);
    send_tick(1'b1, 31'd1000, 32'sd0, 32'sd0, 1'b0, 32'sd655360, 32'sd0, 31'd10);
    send_tick(1'b1, 31'd655360, 32'sd0, 32'sd0, 1'b1, 32'sd655360, 32'sd0, 31'd10);
    drain();

    // Extreme coefficients everywhere.
    for (int i = 0; i < CFG_NUM; i++) coeffs[i] = 64'h7fff_ffff_8000_0000;
    load_coeffs(coeffs);
    repeat (30) random_tick();
    drain();
    for (int i = 0; i < CFG_NUM; i++) coeffs[i] = 64'h8000_0000_7fff_ffff;
    load_coeffs(coeffs);
    repeat (30) random_tick();
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < CFG_NUM; i++) coeffs[i] = {rand_coeff(), rand_coeff()};
      coeffs[CFG_DC_SCALE]  = {rand_scale(), rand_scale()};
      coeffs[CFG_INT_STEPS] = {rand_coeff(), rand_coeff()};
      load_coeffs(coeffs);
      burst_left = 0;
      for (int n = 0; n < 220; n++) begin
        if (burst_left == 0) begin
          no_gaps    = $urandom_range(0, 3) == 0;
          burst_left = $urandom_range(10, 40);
        end
        burst_left--;
        if (phase == 2 && n == 60) hold_request = 1'b1;
        if (phase == 4 && n == 100) drain();
        random_tick();
      end
      no_gaps = 1'b0;
      drain();
    end

    repeat (QUIET_TAIL) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/lsoc_pkg.sv
rtl/lsoc_div.sv
rtl/lsoc_dp.sv
rtl/lsoc_ctrl.sv
rtl/lqr_steering_observer_control.sv
tb/lsoc_checker.sv
tb/tb.sv
